// ===== rtl/msd_pkg.sv =====
// shared constants, types and control encodings for the motor stall detector
`default_nettype none

package msd_pkg;

    localparam int WINDOW     = 60;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int CUR_W      = 12;
    localparam int DT_W       = 10;
    localparam int ST_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CUR_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_THR = CFG_IDX_W'(1);

    localparam logic [CUR_W-1:0] CUR_THR_RST  = CUR_W'(800);
    localparam logic [ST_W-1:0]  TIME_THR_RST = ST_W'(1000);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DEL,
        OP_INS,
        OP_INS_LAST,
        OP_MED
    } lane_op_t;

    typedef struct packed {
        lane_op_t         op;
        logic [IDX_W-1:0] addr;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DEL,
        ST_DEL_DRAIN,
        ST_INS,
        ST_INS_DRAIN,
        ST_INS_LAST,
        ST_MED,
        ST_MED_DRAIN,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/msd_lane.sv =====
// one current channel: sample window, sorted copy kept by sweeps, median readout
`default_nettype none

module msd_lane (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire msd_pkg::lane_ctl_t         ctl,
    input  wire logic [msd_pkg::CUR_W-1:0]  sample,
    output logic      [msd_pkg::CUR_W-1:0]  median
);
    import msd_pkg::*;

    logic [CUR_W-1:0] win_mem [WINDOW];
    logic [CUR_W-1:0] srt_mem [WINDOW];

    logic [CUR_W-1:0] old_reg;
    logic [CUR_W-1:0] srt_q;
    logic [CUR_W-1:0] hold_reg;
    logic [CUR_W-1:0] median_reg;

    lane_op_t         mode_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             found_reg;
    logic             found_next;
    logic             placed_reg;
    logic             placed_next;

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CUR_W-1:0] wr_data;
    logic             med_cap;
    logic [CUR_W:0]   med_sum;

    assign rd_en = (ctl.op == OP_DEL) || (ctl.op == OP_INS) || (ctl.op == OP_MED);

    // window memory, read-first at the overwritten slot
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
        begin
            old_reg             <= win_mem[ctl.addr];
            win_mem[ctl.addr]   <= sample;
        end
    end

    // sorted memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            srt_q <= srt_mem[ctl.addr];
        end
        if (wr_en)
        begin
            srt_mem[wr_addr] <= wr_data;
        end
    end

    // read data arrives in the cycle after the op that issued it
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = sample;
        found_next  = found_reg;
        placed_next = placed_reg;
        med_cap     = 1'b0;
        unique case (mode_reg)
            OP_DEL:
            begin
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - 1'b1;
                    wr_data = srt_q;
                end
                else if (srt_q == old_reg)
                begin
                    found_next = 1'b1;
                end
            end
            OP_INS:
            begin
                if (!placed_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg + 1'b1;
                    if (srt_q > sample)
                    begin
                        wr_data = srt_q;
                    end
                    else
                    begin
                        wr_data     = sample;
                        placed_next = 1'b1;
                    end
                end
            end
            OP_MED:
            begin
                med_cap = 1'b1;
            end
            default:
            begin
            end
        endcase
        // new sample is the smallest
        if ((ctl.op == OP_INS_LAST) && !placed_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = sample;
        end
        if (ctl.op == OP_LOAD)
        begin
            found_next  = 1'b0;
            placed_next = 1'b0;
        end
    end

    assign med_sum = {1'b0, hold_reg} + {1'b0, srt_q};

    always_ff @(posedge clk)
    begin
        if (med_cap)
        begin
            hold_reg   <= srt_q;
            median_reg <= med_sum[CUR_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= OP_NONE;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            placed_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= ctl.op;
            idx_reg    <= ctl.addr;
            found_reg  <= found_next;
            placed_reg <= placed_next;
        end
    end

    assign median = median_reg;

endmodule

`default_nettype wire

// ===== rtl/motor_stall_detector.sv =====
// top level: stream ports, sequencer, stall-time accumulator and result register
`default_nettype none

// Two-motor stall detector. Each input transfer carries one current sample per
// motor and the elapsed milliseconds; each produces exactly one output transfer
// with the running medians over the last 60 samples and the stall flag. Each
// channel keeps its samples in a circular window and a sorted copy in a
// simple dual-port memory that is updated by sweeps: one removal sweep of the
// oldest sample (once the window is full) and one insertion sweep, one entry
// per cycle, followed by two reads for the median. s_tready is low from
// acceptance until the result enters the output register, so the next item
// is not accepted before then. A finished result waits in the output register
// without blocking acceptance of the next item; if that register is still
// occupied when the next result is ready, the sequencer holds in its last
// step until it frees. Configuration writes are always accepted; index 0 is
// the stall current threshold (12 bits), index 1 the stall time threshold in
// ms (16 bits), other indexes are ignored.
module motor_stall_detector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // current_a[11:0], current_b[23:12], elapsed_ms[33:24], zero fill
    input  wire logic [msd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // stalling[0], median_a[12:1], median_b[24:13], zero fill
    output logic      [msd_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [msd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import msd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [IDX_W-1:0]  slot_reg;
    logic [IDX_W-1:0]  slot_next;
    logic [ST_W-1:0]   st_reg;
    logic [ST_W-1:0]   st_next;

    logic [CUR_W-1:0]  cur_thr_reg;
    logic [ST_W-1:0]   time_thr_reg;

    logic [CUR_W-1:0]  ca_reg;
    logic [CUR_W-1:0]  cb_reg;
    logic [DT_W-1:0]   dt_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              stalling_reg;
    logic              stalling_next;
    logic [CUR_W-1:0]  med_a_reg;
    logic [CUR_W-1:0]  med_b_reg;

    lane_ctl_t         ctl;
    logic [CUR_W-1:0]  median_a;
    logic [CUR_W-1:0]  median_b;

    logic              full;
    logic              out_free;
    logic              result_go;
    logic [IDX_W-1:0]  med_hi;
    logic [IDX_W-1:0]  med_lo;
    logic              over_thr;
    logic [ST_W:0]     st_sum;
    logic [ST_W-1:0]   st_up;
    logic [ST_W-1:0]   st_down;

    assign full      = (fill_reg == FILL_W'(WINDOW));
    assign out_free  = !out_valid_reg || m_tready;
    assign result_go = (state_reg == ST_RESULT) && out_free;
    assign med_hi    = IDX_W'(fill_reg >> 1);
    assign med_lo    = fill_reg[0] ? med_hi : (med_hi - 1'b1);

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                slot_next = (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : (slot_reg + 1'b1);
                if (full)
                begin
                    state_next = ST_DEL;
                    cnt_next   = '0;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == '0)
                    begin
                        state_next = ST_INS_LAST;
                    end
                    else
                    begin
                        state_next = ST_INS;
                        cnt_next   = IDX_W'(fill_reg - 1'b1);
                    end
                end
            end
            ST_DEL:
            begin
                if (cnt_reg == IDX_W'(WINDOW - 1))
                begin
                    state_next = ST_DEL_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DEL_DRAIN:
            begin
                state_next = ST_INS;
                cnt_next   = IDX_W'(WINDOW - 2);
            end
            ST_INS:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_INS_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_INS_DRAIN:
            begin
                state_next = ST_INS_LAST;
            end
            ST_INS_LAST:
            begin
                state_next = ST_MED;
                cnt_next   = '0;
            end
            ST_MED:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next = IDX_W'(1);
                end
                else
                begin
                    state_next = ST_MED_DRAIN;
                end
            end
            ST_MED_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // lane control
    always_comb
    begin
        ctl.op   = OP_NONE;
        ctl.addr = cnt_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                ctl.op   = OP_LOAD;
                ctl.addr = slot_reg;
            end
            ST_DEL:
            begin
                ctl.op = OP_DEL;
            end
            ST_INS:
            begin
                ctl.op = OP_INS;
            end
            ST_INS_LAST:
            begin
                ctl.op = OP_INS_LAST;
            end
            ST_MED:
            begin
                ctl.op   = OP_MED;
                ctl.addr = (cnt_reg == '0) ? med_lo : med_hi;
            end
            default:
            begin
                ctl.op = OP_NONE;
            end
        endcase
    end

    // stall-time accumulator, saturating at the top and clamped at zero
    assign over_thr = (median_a > cur_thr_reg) || (median_b > cur_thr_reg);
    assign st_sum   = {1'b0, st_reg} + {{(ST_W + 1 - DT_W){1'b0}}, dt_reg};
    assign st_up    = st_sum[ST_W] ? {ST_W{1'b1}} : st_sum[ST_W-1:0];
    assign st_down  = (st_reg > ST_W'(dt_reg)) ? (st_reg - ST_W'(dt_reg)) : '0;

    always_comb
    begin
        st_next        = st_reg;
        stalling_next  = stalling_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (result_go)
        begin
            st_next        = over_thr ? st_up : st_down;
            stalling_next  = (st_next >= time_thr_reg);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
            cur_thr_reg   <= CUR_THR_RST;
            time_thr_reg  <= TIME_THR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CUR_THR:  cur_thr_reg  <= cfg_data[CUR_W-1:0];
                    REG_TIME_THR: time_thr_reg <= cfg_data[ST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ca_reg <= s_tdata[CUR_W-1:0];
            cb_reg <= s_tdata[2*CUR_W-1:CUR_W];
            dt_reg <= s_tdata[2*CUR_W+DT_W-1:2*CUR_W];
        end
        if (result_go)
        begin
            stalling_reg <= stalling_next;
            med_a_reg    <= median_a;
            med_b_reg    <= median_b;
        end
    end

    msd_lane u_lane_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (ca_reg),
        .median (median_a)
    );

    msd_lane u_lane_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sample (cb_reg),
        .median (median_b)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W - 2*CUR_W - 1){1'b0}}, med_b_reg, med_a_reg, stalling_reg};

endmodule

`default_nettype wire
